// ----- rtl/uri_enc_pkg.sv -----
package uri_enc_pkg;

    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 16;
    localparam int CompW    = 3;
    localparam int CountW   = 16;

    // register indexes on the configuration port
    localparam logic [CfgIdxW-1:0] REG_COMPONENT    = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_KEEP_ESCAPES = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_OUT_SIZE     = 2'd2;

    // URI component codes
    localparam logic [CompW-1:0] COMP_PATH     = 3'd0;
    localparam logic [CompW-1:0] COMP_SEGMENT  = 3'd1;
    localparam logic [CompW-1:0] COMP_QUERY    = 3'd2;
    localparam logic [CompW-1:0] COMP_FRAGMENT = 3'd3;
    localparam logic [CompW-1:0] COMP_USERINFO = 3'd4;
    localparam logic [CompW-1:0] COMP_HOST     = 3'd5;
    localparam logic [CompW-1:0] COMP_FORM     = 3'd6;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QMARK = 8'h3F;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       byte_present;
        logic       end_of_string;
    } uri_in_t;

    typedef struct packed {
        logic [7:0]        out_byte;
        logic              byte_valid;
        logic              run_last;
        logic              overflow;
        logic [CountW-1:0] out_count;
    } uri_out_t;

    typedef struct packed {
        logic [CompW-1:0]  component;
        logic              keep_escapes;
        logic [CountW-1:0] out_size;
    } uri_cfg_t;

    typedef struct packed {
        logic     emit;
        logic     done;
        uri_out_t res;
    } uri_push_t;

    // one output unit: a single byte or a three-byte triplet
    typedef struct packed {
        logic       three;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } uri_unit_t;

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return 8'h30 + {4'h0, n};
        end else begin
            return 8'h37 + {4'h0, n};
        end
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h66) begin
            return c - 8'h20;
        end else begin
            return c;
        end
    endfunction

    function automatic logic plain_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || c == 8'h2D || c == 8'h2E ||
               c == 8'h5F || c == 8'h7E;
    endfunction

    function automatic logic sub_delim(input logic [7:0] c);
        logic r;
        case (c)
            8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29,
            8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic passes(input logic [7:0] c, input logic [CompW-1:0] comp);
        logic r;
        case (comp)
            COMP_PATH:     r = sub_delim(c) || c == CH_COLON || c == CH_AT || c == CH_SLASH;
            COMP_SEGMENT:  r = sub_delim(c) || c == CH_COLON || c == CH_AT;
            COMP_QUERY, COMP_FRAGMENT:
                r = sub_delim(c) || c == CH_COLON || c == CH_AT || c == CH_SLASH ||
                    c == CH_QMARK;
            COMP_USERINFO: r = sub_delim(c) || c == CH_COLON;
            COMP_HOST:     r = sub_delim(c);
            default:       r = 1'b0;
        endcase
        return plain_char(c) || r;
    endfunction

    function automatic uri_unit_t encode_plain(input logic [7:0] c,
                                               input logic [CompW-1:0] comp);
        uri_unit_t u;
        u = '0;
        if (comp == COMP_FORM && c == CH_SPACE) begin
            u.b0 = CH_PLUS;
        end else if (passes(c, comp)) begin
            u.b0 = c;
        end else begin
            u.three = 1'b1;
            u.b0    = CH_PCT;
            u.b1    = hex_char(c[7:4]);
            u.b2    = hex_char(c[3:0]);
        end
        return u;
    endfunction

    function automatic uri_unit_t triplet(input logic [7:0] d, input logic [7:0] c);
        uri_unit_t u;
        u.three = 1'b1;
        u.b0    = CH_PCT;
        u.b1    = upcase(d);
        u.b2    = upcase(c);
        return u;
    endfunction

endpackage

// ----- rtl/uri_enc_engine.sv -----
module uri_enc_engine import uri_enc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  uri_cfg_t  cfg,
    input  logic      s_valid,
    output logic      s_ready,
    input  uri_in_t   s_data,
    input  logic      can_push,
    output uri_push_t push
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_TAKE  = 3'd1;
    localparam logic [2:0] PH_DIG   = 3'd2;
    localparam logic [2:0] PH_FRESH = 3'd3;
    localparam logic [2:0] PH_END   = 3'd4;
    localparam logic [2:0] PH_EDIG  = 3'd5;
    localparam logic [2:0] PH_RPT   = 3'd6;

    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_PCT   = 2'd1;
    localparam logic [1:0] PEND_DIGIT = 2'd2;

    logic [2:0]        phase_reg, phase_next;
    logic [1:0]        burst_reg, burst_next;
    logic [7:0]        b1_reg, b1_next;
    logic [7:0]        b2_reg, b2_next;
    logic [7:0]        byte_reg, byte_next;
    logic              end_reg, end_next;
    logic [1:0]        pend_reg, pend_next;
    logic [7:0]        digit_reg, digit_next;
    logic [CountW-1:0] count_reg, count_next;
    logic              ovf_reg, ovf_next;

    logic [2:0]        nxt;
    logic [1:0]        pend_step;
    logic [7:0]        digit_step;
    logic              unit_req;
    uri_unit_t         unit;
    logic              report;
    logic              fresh_keep;
    logic [CountW:0]   sum;
    logic              unit_fit;
    logic              unit_ovf;
    logic              in_burst;
    logic              busy;
    logic              want_emit;
    logic              adv;
    logic              done;
    logic              accept;

    assign fresh_keep = cfg.keep_escapes && byte_reg == CH_PCT;

    // decode the current step of the item
    always_comb begin
        nxt        = PH_IDLE;
        pend_step  = pend_reg;
        digit_step = digit_reg;
        unit_req   = 1'b0;
        unit       = '0;
        report     = 1'b0;
        case (phase_reg)
            PH_TAKE: begin
                nxt = PH_END;
                if (ovf_reg) begin
                    pend_step = PEND_NONE;
                end else begin
                    case (pend_reg)
                        PEND_NONE: begin
                            if (fresh_keep) begin
                                pend_step = PEND_PCT;
                            end else begin
                                unit_req = 1'b1;
                                unit     = encode_plain(byte_reg, cfg.component);
                            end
                        end
                        PEND_PCT: begin
                            if (is_hex(byte_reg)) begin
                                digit_step = byte_reg;
                                pend_step  = PEND_DIGIT;
                            end else begin
                                pend_step = PEND_NONE;
                                unit_req  = 1'b1;
                                unit      = encode_plain(CH_PCT, cfg.component);
                                nxt       = PH_FRESH;
                            end
                        end
                        default: begin
                            pend_step = PEND_NONE;
                            unit_req  = 1'b1;
                            if (is_hex(byte_reg)) begin
                                unit = triplet(digit_reg, byte_reg);
                            end else begin
                                unit = encode_plain(CH_PCT, cfg.component);
                                nxt  = PH_DIG;
                            end
                        end
                    endcase
                end
            end
            PH_DIG: begin
                nxt      = PH_FRESH;
                unit_req = 1'b1;
                unit     = encode_plain(digit_reg, cfg.component);
            end
            PH_FRESH: begin
                nxt = PH_END;
                if (!ovf_reg) begin
                    if (fresh_keep) begin
                        pend_step = PEND_PCT;
                    end else begin
                        unit_req = 1'b1;
                        unit     = encode_plain(byte_reg, cfg.component);
                    end
                end
            end
            PH_END: begin
                nxt = PH_EDIG;
                if (pend_reg != PEND_NONE) begin
                    unit_req = 1'b1;
                    unit     = encode_plain(CH_PCT, cfg.component);
                end
            end
            PH_EDIG: begin
                nxt = PH_RPT;
                if (pend_reg == PEND_DIGIT) begin
                    unit_req = 1'b1;
                    unit     = encode_plain(digit_reg, cfg.component);
                end
            end
            PH_RPT: begin
                nxt       = PH_IDLE;
                pend_step = PEND_NONE;
                report    = 1'b1;
            end
            default: nxt = PH_IDLE;
        endcase
        // no end marker: the item finishes after its byte
        if (nxt == PH_END && !end_reg) begin
            nxt = PH_IDLE;
        end
    end

    assign sum       = {1'b0, count_reg} + (unit.three ? 17'd3 : 17'd1);
    assign unit_fit  = unit_req && !ovf_reg && (sum < {1'b0, cfg.out_size});
    assign unit_ovf  = unit_req && !ovf_reg && !unit_fit;
    assign in_burst  = burst_reg != 2'd0;
    assign busy      = phase_reg != PH_IDLE || in_burst;
    assign want_emit = in_burst || unit_fit || report;
    assign adv       = busy && (!want_emit || can_push);

    always_comb begin
        phase_next = phase_reg;
        burst_next = burst_reg;
        b1_next    = b1_reg;
        b2_next    = b2_reg;
        byte_next  = byte_reg;
        end_next   = end_reg;
        pend_next  = pend_reg;
        digit_next = digit_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        push       = '0;
        if (adv) begin
            if (in_burst) begin
                // drain a triplet's tail, one per cycle unless stalled
                push.emit           = 1'b1;
                push.res.out_byte   = b1_reg;
                push.res.byte_valid = 1'b1;
                push.res.overflow   = ovf_reg;
                push.res.out_count  = count_reg + 16'd1;
                count_next          = count_reg + 16'd1;
                b1_next             = b2_reg;
                burst_next          = burst_reg - 2'd1;
            end else begin
                phase_next = nxt;
                pend_next  = pend_step;
                digit_next = digit_step;
                if (unit_fit) begin
                    push.emit           = 1'b1;
                    push.res.out_byte   = unit.b0;
                    push.res.byte_valid = 1'b1;
                    push.res.overflow   = ovf_reg;
                    push.res.out_count  = count_reg + 16'd1;
                    count_next          = count_reg + 16'd1;
                    burst_next          = unit.three ? 2'd2 : 2'd0;
                    b1_next             = unit.b1;
                    b2_next             = unit.b2;
                end
                if (unit_ovf) begin
                    ovf_next = 1'b1;
                end
                if (report) begin
                    push.emit          = 1'b1;
                    push.res.overflow  = ovf_reg || cfg.out_size == 16'd0;
                    push.res.out_count = count_reg;
                    count_next         = '0;
                    ovf_next           = 1'b0;
                end
            end
        end
        done      = adv && phase_next == PH_IDLE && burst_next == 2'd0;
        push.done = done;
        s_ready   = !busy || done;
        accept    = s_valid && s_ready;
        if (accept) begin
            byte_next = s_data.in_byte;
            end_next  = s_data.end_of_string;
            if (s_data.byte_present) begin
                phase_next = PH_TAKE;
            end else if (s_data.end_of_string) begin
                phase_next = PH_END;
            end else begin
                phase_next = PH_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            burst_reg <= 2'd0;
            pend_reg  <= PEND_NONE;
            digit_reg <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            burst_reg <= burst_next;
            pend_reg  <= pend_next;
            digit_reg <= digit_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        b1_reg   <= b1_next;
        b2_reg   <= b2_next;
        byte_reg <= byte_next;
        end_reg  <= end_next;
    end

endmodule

// ----- rtl/uri_enc_out.sv -----
module uri_enc_out import uri_enc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  uri_push_t push,
    output logic      can_push,
    output logic      m_valid,
    input  logic      m_ready,
    output uri_out_t  m_data
);

    logic     hold_valid_reg, hold_valid_next;
    logic     hold_last_reg, hold_last_next;
    uri_out_t hold_data_reg, hold_data_next;
    logic     out_valid_reg, out_valid_next;
    uri_out_t out_data_reg, out_data_next;

    logic out_free;
    logic move;

    // the held result goes out once its successor or the end of its item is known
    assign out_free = !out_valid_reg || m_ready;
    assign move     = hold_valid_reg && (hold_last_reg || push.emit) && out_free;
    assign can_push = !hold_valid_reg || out_free;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        hold_valid_next = hold_valid_reg;
        hold_last_next  = hold_last_reg;
        hold_data_next  = hold_data_reg;
        if (move) begin
            out_valid_next         = 1'b1;
            out_data_next          = hold_data_reg;
            out_data_next.run_last = hold_last_reg;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (push.emit) begin
            hold_valid_next = 1'b1;
            hold_last_next  = push.done;
            hold_data_next  = push.res;
        end else if (move) begin
            hold_valid_next = 1'b0;
            hold_last_next  = 1'b0;
        end else if (push.done && hold_valid_reg) begin
            hold_last_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            hold_last_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            hold_last_reg  <= hold_last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_data_reg <= hold_data_next;
        out_data_reg  <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ----- rtl/uri_percent_encoder.sv -----
// Streaming percent-encoder for one URI component. Each input transaction carries one byte,
// an end-of-string mark, both, or neither (no output); each output transaction carries one
// encoded byte, and the last transaction of every string is a report with byte_valid low
// that gives the overflow flag and the byte count. run_last marks the final output of each
// input transaction. A byte that passes through or becomes '+' is one unit, so such bytes
// stream at one per cycle while the result channel is free; a %HH escape leaves as three
// bytes over the one-byte-wide result channel. A broken %X triplet replays its held bytes
// as ordinary bytes, and an end mark flushes held bytes before the report. The sequencer
// evaluates one output unit per cycle while no triplet drains and the channel is free; a
// result leaves through one hold stage, which it quits once its successor or its item's end
// is known, and then the output register. Write configuration only while the block is idle.
module uri_percent_encoder import uri_enc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  uri_in_t             s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output uri_out_t            m_data
);

    logic [CompW-1:0]  component_reg, component_next;
    logic              keep_reg, keep_next;
    logic [CountW-1:0] size_reg, size_next;

    uri_cfg_t  cfg;
    uri_push_t push;
    logic      can_push;

    always_comb begin
        component_next = component_reg;
        keep_next      = keep_reg;
        size_next      = size_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_COMPONENT:    component_next = cfg_wdata[CompW-1:0];
                REG_KEEP_ESCAPES: keep_next      = cfg_wdata[0];
                REG_OUT_SIZE:     size_next      = cfg_wdata[CountW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            component_reg <= COMP_PATH;
            keep_reg      <= 1'b1;
            size_reg      <= 16'hFFFF;
        end else begin
            component_reg <= component_next;
            keep_reg      <= keep_next;
            size_reg      <= size_next;
        end
    end

    assign cfg.component    = component_reg;
    assign cfg.keep_escapes = keep_reg;
    assign cfg.out_size     = size_reg;

    uri_enc_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .can_push (can_push),
        .push     (push)
    );

    uri_enc_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .can_push (can_push),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ----- tb/uri_enc_checker.sv -----
module uri_enc_checker import uri_enc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_wdata,
    input  logic                s_valid,
    input  logic                s_ready,
    input  uri_in_t             s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  uri_out_t            m_data,
    output int                  mismatch_count,
    output int                  awaited,
    output int                  results_checked,
    output int                  reports_checked,
    output int                  overflow_reports
);

    localparam logic [8*16-1:0] HEX_DIGITS   = "0123456789ABCDEF";
    localparam int              REPORT_LIMIT = 10;

    // register copies
    logic [CompW-1:0]  comp_sel;
    logic              keep_pct;
    logic [CountW-1:0] size_limit;

    // encoder state
    logic [1:0]        held_count;
    logic [7:0]        held_digit;
    logic [CountW-1:0] written_count;
    logic              overflowed;

    uri_out_t encoded_q[$];

    function automatic int hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return int'(c - "0");
        end else if (c >= "a" && c <= "f") begin
            return int'(c - "a") + 10;
        end else if (c >= "A" && c <= "F") begin
            return int'(c - "A") + 10;
        end
        return -1;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        return HEX_DIGITS[8*(15-n) +: 8];
    endfunction

    function automatic logic unreserved(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
               c == "-" || c == "." || c == "_" || c == "~";
    endfunction

    function automatic logic sub_delim(input logic [7:0] c);
        return c == "!" || c == "$" || c == "&" || c == "'" || c == "(" || c == ")" ||
               c == "*" || c == "+" || c == "," || c == ";" || c == "=";
    endfunction

    function automatic logic allowed(input logic [7:0] c);
        logic extra;
        case (comp_sel)
            COMP_PATH: begin
                extra = sub_delim(c) || c == CH_COLON || c == CH_AT || c == CH_SLASH;
            end
            COMP_SEGMENT: begin
                extra = sub_delim(c) || c == CH_COLON || c == CH_AT;
            end
            COMP_QUERY, COMP_FRAGMENT: begin
                extra = sub_delim(c) || c == CH_COLON || c == CH_AT || c == CH_SLASH ||
                        c == CH_QMARK;
            end
            COMP_USERINFO: begin
                extra = sub_delim(c) || c == CH_COLON;
            end
            COMP_HOST: begin
                extra = sub_delim(c);
            end
            default: begin
                extra = 1'b0;
            end
        endcase
        return unreserved(c) || extra;
    endfunction

    task automatic push_result(input logic [7:0] b, input logic valid);
        uri_out_t r;
        r.out_byte   = b;
        r.byte_valid = valid;
        r.run_last   = 1'b0;
        r.overflow   = overflowed;
        r.out_count  = written_count;
        encoded_q.push_back(r);
    endtask

    // emit a whole unit or nothing; a unit that does not fit sets the sticky flag
    task automatic put_unit(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
                            input int len);
        logic [7:0] unit_bytes [3];
        int k;
        unit_bytes[0] = b0;
        unit_bytes[1] = b1;
        unit_bytes[2] = b2;
        if (!overflowed) begin
            if (int'(written_count) + len >= int'(size_limit)) begin
                overflowed = 1'b1;
            end else begin
                for (k = 0; k < len; k++) begin
                    written_count = written_count + 1'b1;
                    push_result(unit_bytes[k], 1'b1);
                end
            end
        end
    endtask

    task automatic encode_byte(input logic [7:0] c);
        if (comp_sel == COMP_FORM && c == CH_SPACE) begin
            put_unit(CH_PLUS, 8'h00, 8'h00, 1);
        end else if (allowed(c)) begin
            put_unit(c, 8'h00, 8'h00, 1);
        end else begin
            put_unit(CH_PCT, hex_digit(c[7:4]), hex_digit(c[3:0]), 3);
        end
    endtask

    task automatic open_byte(input logic [7:0] c);
        if (keep_pct && c == CH_PCT) begin
            held_count = 2'd1;
        end else begin
            encode_byte(c);
        end
    endtask

    task automatic take_byte(input logic [7:0] c);
        if (overflowed) begin
            held_count = 2'd0;
        end else if (held_count == 2'd0) begin
            open_byte(c);
        end else if (held_count == 2'd1) begin
            if (hex_value(c) >= 0) begin
                held_digit = c;
                held_count = 2'd2;
            end else begin
                // broken after '%': replay it, then treat the breaking byte afresh
                held_count = 2'd0;
                encode_byte(CH_PCT);
                if (!overflowed) begin
                    open_byte(c);
                end
            end
        end else begin
            held_count = 2'd0;
            if (hex_value(c) >= 0) begin
                put_unit(CH_PCT, hex_digit(4'(hex_value(held_digit))),
                         hex_digit(4'(hex_value(c))), 3);
            end else begin
                encode_byte(CH_PCT);
                encode_byte(held_digit);
                if (!overflowed) begin
                    open_byte(c);
                end
            end
        end
    endtask

    task automatic encode_transaction(input uri_in_t it);
        uri_out_t r;
        int first;
        first = encoded_q.size();
        if (it.byte_present) begin
            take_byte(it.in_byte);
        end
        if (it.end_of_string) begin
            if (!overflowed) begin
                if (held_count >= 2'd1) begin
                    encode_byte(CH_PCT);
                end
                if (held_count == 2'd2) begin
                    encode_byte(held_digit);
                end
            end
            held_count = 2'd0;
            if (size_limit == '0) begin
                overflowed = 1'b1;
            end
            push_result(8'h00, 1'b0);
            written_count = '0;
            overflowed    = 1'b0;
        end
        if (encoded_q.size() > first) begin
            r = encoded_q.pop_back();
            r.run_last = 1'b1;
            encoded_q.push_back(r);
        end
    endtask

    task automatic check_result(input uri_out_t got);
        uri_out_t want;
        if (encoded_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("%0t: result with none awaited:", $realtime);
                $display("  byte %02h valid %0b last %0b ovf %0b count %0d",
                         got.out_byte, got.byte_valid, got.run_last, got.overflow,
                         got.out_count);
            end
        end else begin
            want = encoded_q.pop_front();
            results_checked++;
            if (!want.byte_valid) begin
                reports_checked++;
                if (want.overflow) begin
                    overflow_reports++;
                end
            end
            if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                got.run_last !== want.run_last || got.overflow !== want.overflow ||
                got.out_count !== want.out_count) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("%0t: result %0d mismatch", $realtime, results_checked);
                    $display("  expected byte %02h valid %0b last %0b ovf %0b count %0d",
                             want.out_byte, want.byte_valid, want.run_last, want.overflow,
                             want.out_count);
                    $display("  actual   byte %02h valid %0b last %0b ovf %0b count %0d",
                             got.out_byte, got.byte_valid, got.run_last, got.overflow,
                             got.out_count);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            comp_sel         = COMP_PATH;
            keep_pct         = 1'b1;
            size_limit       = '1;
            held_count       = 2'd0;
            held_digit       = 8'h00;
            written_count    = '0;
            overflowed       = 1'b0;
            mismatch_count   = 0;
            results_checked  = 0;
            reports_checked  = 0;
            overflow_reports = 0;
            encoded_q.delete();
        end else begin
            // outputs first: a result never belongs to an input taken at the same edge
            if (m_valid && m_ready) begin
                check_result(m_data);
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_COMPONENT:    comp_sel   = cfg_wdata[CompW-1:0];
                    REG_KEEP_ESCAPES: keep_pct   = cfg_wdata[0];
                    REG_OUT_SIZE:     size_limit = cfg_wdata[CountW-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                encode_transaction(s_data);
            end
        end
        awaited <= encoded_q.size();
    end

endmodule

// ----- tb/testbench.sv -----
module testbench;
    import uri_enc_pkg::*;

    localparam int               CYCLE_LIMIT = 400000;
    localparam int               LONG_HOLD   = 150;
    localparam int               SETTLE      = 16;
    localparam int               PHASES      = 12;
    localparam int               PHASE_ITEMS = 20;
    localparam int               HOLD_PHASE  = 4;
    localparam logic [CompW-1:0] COMP_SPARE  = 3'd7;
    localparam logic [15:0]      SIZE_MAX    = 16'hFFFF;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    uri_in_t             s_data;
    logic                m_valid;
    logic                m_ready;
    uri_out_t            m_data;

    int mismatch_count;
    int awaited;
    int results_checked;
    int reports_checked;
    int overflow_reports;

    int   cycle_count   = 0;
    int   items_sent    = 0;
    int   settings_used = 0;
    int   hold_requests = 0;
    logic quiet         = 1'b0;

    string hex_pool   = "0123456789abcdefABCDEF";
    string plain_pool = "abcxyzABCXYZ0189-._~";
    string punct_pool = "!$&'()*+,;=:@/?#[]\"<>\\^`{|} %";

    uri_percent_encoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    uri_enc_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data           (s_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data),
        .mismatch_count   (mismatch_count),
        .awaited          (awaited),
        .results_checked  (results_checked),
        .reports_checked  (reports_checked),
        .overflow_reports (overflow_reports)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still awaited", cycle_count, awaited);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold on request, none at the end
    initial begin
        int sink_gap;
        int hold_left;
        int holds_served;
        sink_gap     = 0;
        hold_left    = 0;
        holds_served = 0;
        m_ready      = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_requests > holds_served) begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else if (quiet) begin
                m_ready = 1'b1;
            end else if (sink_gap > 0) begin
                m_ready = 1'b0;
                sink_gap--;
            end else begin
                m_ready = 1'b1;
                if ($urandom_range(0, 9) == 0) begin
                    sink_gap = $urandom_range(1, 12);
                end
            end
        end
    end

    function automatic uri_in_t make_item(input logic [7:0] b, input logic present,
                                          input logic eos);
        uri_in_t it;
        it.in_byte       = b;
        it.byte_present  = present;
        it.end_of_string = eos;
        return it;
    endfunction

    function automatic logic [7:0] pick_hex();
        return hex_pool[$urandom_range(0, hex_pool.len() - 1)];
    endfunction

    task automatic pause(input int n);
        s_valid = 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    // offer at the falling edge, hold until taken, leave at the next falling edge
    task automatic send_item(input uri_in_t it);
        s_data  = it;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            pause($urandom_range(1, 12));
        end
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (awaited != 0) @(negedge aclk);
        // a held '%' or a dropped byte leaves nothing to wait for; let the block settle
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic apply_setting(input logic [CompW-1:0] comp, input logic keep,
                                 input logic [15:0] size);
        cfg_wr_en = 1'b1;
        cfg_index = REG_COMPONENT;
        cfg_wdata = CfgDataW'(comp);
        @(negedge aclk);
        cfg_index = REG_KEEP_ESCAPES;
        cfg_wdata = CfgDataW'(keep);
        @(negedge aclk);
        cfg_index = REG_OUT_SIZE;
        cfg_wdata = size;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        settings_used++;
    endtask

    task automatic send_string(input int n_bytes);
        logic [7:0] text[$];
        bit         split_end;
        int         k;
        while (text.size() < n_bytes) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    text.push_back(CH_PCT);
                    text.push_back(pick_hex());
                    text.push_back(pick_hex());
                end
                2: begin
                    // usually a broken triplet
                    text.push_back(CH_PCT);
                    if ($urandom_range(0, 1)) begin
                        text.push_back(pick_hex());
                    end
                    text.push_back(8'($urandom_range(0, 255)));
                end
                3: text.push_back(8'($urandom_range(0, 255)));
                4: text.push_back(CH_SPACE);
                5, 6: text.push_back(punct_pool[$urandom_range(0, punct_pool.len() - 1)]);
                default: text.push_back(plain_pool[$urandom_range(0, plain_pool.len() - 1)]);
            endcase
        end
        split_end = (text.size() == 0) || ($urandom_range(0, 3) == 0);
        for (k = 0; k < text.size(); k++) begin
            send_item(make_item(text[k], 1'b1, (k == text.size() - 1) && !split_end));
            if ($urandom_range(0, 15) == 0) begin
                send_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
            end
        end
        if (split_end) begin
            send_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
        end
    endtask

    function automatic logic [15:0] phase_size(input int p);
        case (p)
            0, 4, 11: return SIZE_MAX;
            1:        return 16'd0;
            2:        return 16'd1;
            3:        return 16'd4;
            5:        return 16'd3;
            6:        return 16'd24;
            7:        return 16'd2;
            8:        return 16'd9;
            9:        return 16'($urandom_range(0, 40));
            default:  return 16'd16;
        endcase
    endfunction

    initial begin
        int               p;
        int               start;
        logic [CompW-1:0] comp;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_COMPONENT;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset settings: path, keep triplets, largest buffer
        send_item(make_item(8'h00, 1'b1, 1'b0));
        send_item(make_item(8'hFF, 1'b1, 1'b0));
        send_item(make_item("a", 1'b1, 1'b0));
        send_item(make_item(CH_SPACE, 1'b1, 1'b0));
        send_item(make_item(CH_SLASH, 1'b1, 1'b0));
        send_item(make_item(CH_PCT, 1'b1, 1'b0));
        send_item(make_item("a", 1'b1, 1'b0));
        send_item(make_item("f", 1'b1, 1'b0));
        send_item(make_item(CH_PCT, 1'b1, 1'b0));
        send_item(make_item("g", 1'b1, 1'b0));
        send_item(make_item(CH_PCT, 1'b1, 1'b0));
        send_item(make_item("4", 1'b1, 1'b0));
        send_item(make_item("z", 1'b1, 1'b0));
        // the breaking '%' opens a new triplet
        send_item(make_item(CH_PCT, 1'b1, 1'b0));
        send_item(make_item(CH_PCT, 1'b1, 1'b0));
        send_item(make_item("4", 1'b1, 1'b0));
        send_item(make_item("1", 1'b1, 1'b1));
        send_item(make_item(CH_PCT, 1'b1, 1'b1));
        send_item(make_item(CH_PCT, 1'b1, 1'b0));
        send_item(make_item("B", 1'b1, 1'b0));
        send_item(make_item("B", 1'b0, 1'b1));
        send_item(make_item("x", 1'b0, 1'b0));
        send_item(make_item(8'h00, 1'b0, 1'b1));
        // flush of two held bytes plus an escape and the report: the widest transaction
        send_item(make_item(CH_PCT, 1'b1, 1'b0));
        send_item(make_item("4", 1'b1, 1'b0));
        send_item(make_item(8'hFF, 1'b1, 1'b1));
        drain();

        // clear keep-escapes with a '%' held; the triplet still completes
        send_item(make_item(CH_PCT, 1'b1, 1'b0));
        drain();
        apply_setting(COMP_PATH, 1'b0, SIZE_MAX);
        send_item(make_item("c", 1'b1, 1'b0));
        send_item(make_item("3", 1'b1, 1'b1));
        drain();

        for (p = 0; p < PHASES; p++) begin
            comp = (p < 8) ? CompW'(p) : CompW'($urandom_range(0, 6));
            if (p == 7) begin
                comp = COMP_SPARE;
            end else if (p == 8) begin
                comp = COMP_FORM;
            end
            apply_setting(comp, (p % 3) != 1, phase_size(p));
            if (p == PHASES - 1) begin
                quiet = 1'b1;
            end
            if (p == HOLD_PHASE) begin
                hold_requests++;
            end
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                send_string($urandom_range(0, 10));
            end
            drain();
        end

        $display("Sent %0d input transactions across %0d register settings (all components,",
                 items_sent, settings_used);
        $display("both escape modes, buffers 0 to 65535); checked %0d results,",
                 results_checked);
        $display("%0d reports, %0d with overflow.", reports_checked, overflow_reports);
        if (mismatch_count == 0 && awaited == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- uri_percent_encoder.f -----
rtl/uri_enc_pkg.sv
rtl/uri_enc_engine.sv
rtl/uri_enc_out.sv
rtl/uri_percent_encoder.sv
tb/uri_enc_checker.sv
tb/testbench.sv
